// File: hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the tick-driven 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_NUM     = 8;
  localparam int CFG_IDX_W   = $clog2(CFG_NUM);
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_NUM-1:0][CFG_WIDTH-1:0] cfg_bank_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_PULSE     = 3'd0,
    REG_SLOT          = 3'd1,
    REG_RECOVERY      = 3'd2,
    REG_RESET_LOW     = 3'd3,
    REG_PRESENCE_WAIT = 3'd4,
    REG_RESET_TAIL    = 3'd5,
    REG_SAMPLE_DELAY  = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_t;

  localparam cfg_bank_t CFG_RESET = '{
    16'd55,   // read tail
    16'd10,   // sample delay
    16'd410,  // reset tail
    16'd90,   // presence wait
    16'd500,  // reset low
    16'd10,   // recovery
    16'd60,   // slot
    16'd3     // low pulse
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_W_LOW    = 10'b00_0001_0000,
    PH_W_DATA   = 10'b00_0010_0000,
    PH_W_REC    = 10'b00_0100_0000,
    PH_R_LOW    = 10'b00_1000_0000,
    PH_R_WAIT   = 10'b01_0000_0000,
    PH_R_TAIL   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic       line_release;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic [7:0] crc_value;
    logic       rejected;
  } result_t;

endpackage

// File: hw/rtl/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Bank of slot timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output cfg_bank_t            cfg_bank
);

  cfg_bank_t bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= CFG_RESET;
    end else if (cfg_write) begin
      bank[cfg_index] <= cfg_data;
    end
  end

  assign cfg_bank = bank;

endmodule

// File: hw/rtl/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core
// Slot timing state machine, bit shifter and CRC-8. Advances once per beat.
// ----------------------------------------------------------------------------
module owbm_core
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_bank_t  cfg_bank,
  input  logic [1:0] opcode,
  input  logic       line_sample,
  input  logic [7:0] write_data,
  output result_t    result
);

  phase_t     phase, phase_next;
  count_t     tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] crc_reg, crc_reg_next;
  logic       presence_flag, presence_flag_next;
  logic       drive_release, drive_release_next;
  logic [7:0] last_read, last_read_next;
  logic       done, rej;

  logic [CFG_WIDTH-1:0] phase_len;
  count_t               count_inc;
  logic                 phase_end;
  logic [2:0]           bit_inc;
  logic                 crc_fb;
  logic [7:0]           crc_shift;

  always_comb begin
    unique case (phase)
      PH_RST_LOW:  phase_len = cfg_bank[REG_RESET_LOW];
      PH_RST_WAIT: phase_len = cfg_bank[REG_PRESENCE_WAIT];
      PH_RST_TAIL: phase_len = cfg_bank[REG_RESET_TAIL];
      PH_W_LOW:    phase_len = cfg_bank[REG_LOW_PULSE];
      PH_W_DATA:   phase_len = cfg_bank[REG_SLOT];
      PH_W_REC:    phase_len = cfg_bank[REG_RECOVERY];
      PH_R_LOW:    phase_len = cfg_bank[REG_LOW_PULSE];
      PH_R_WAIT:   phase_len = cfg_bank[REG_SAMPLE_DELAY];
      PH_R_TAIL:   phase_len = cfg_bank[REG_READ_TAIL];
      default:     phase_len = '0;
    endcase
  end

  // The counter saturates, and a saturated counter ends the phase.
  assign count_inc = (tick_count == COUNT_MAX) ? tick_count : tick_count + count_t'(1);
  assign phase_end = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(phase_len)) ||
                     (count_inc == COUNT_MAX);
  assign bit_inc   = bit_index + 3'd1;
  assign crc_fb    = crc_reg[0] ^ line_sample;
  assign crc_shift = {1'b0, crc_reg[7:1]} ^ (crc_fb ? CRC_POLY : 8'h00);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    crc_reg_next       = crc_reg;
    presence_flag_next = presence_flag;
    drive_release_next = drive_release;
    last_read_next     = last_read;
    done               = 1'b0;
    rej                = 1'b0;

    if (opcode_t'(opcode) != OP_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_count_next    = '0;
        drive_release_next = 1'b0;
        bit_index_next     = '0;
        unique case (opcode_t'(opcode))
          OP_RESET: begin
            bit_index_next = bit_index;
            crc_reg_next   = '0;
            phase_next     = PH_RST_LOW;
          end
          OP_WRITE: begin
            shift_byte_next = write_data;
            phase_next      = PH_W_LOW;
          end
          OP_READ: begin
            shift_byte_next = '0;
            phase_next      = PH_R_LOW;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = count_inc;
      if (phase_end) begin
        tick_count_next    = '0;
        drive_release_next = 1'b1;
        unique case (phase)
          PH_RST_LOW: begin
            phase_next = PH_RST_WAIT;
          end
          PH_RST_WAIT: begin
            presence_flag_next = ~line_sample;
            phase_next         = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_W_LOW: begin
            phase_next         = PH_W_DATA;
            drive_release_next = shift_byte[0];
          end
          PH_W_DATA, PH_W_REC: begin
            if ((phase == PH_W_DATA) && !shift_byte[0]) begin
              phase_next = PH_W_REC;
            end else begin
              bit_index_next  = bit_inc;
              shift_byte_next = {1'b0, shift_byte[7:1]};
              if (bit_inc == 3'd0) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end else begin
                phase_next         = PH_W_LOW;
                drive_release_next = 1'b0;
              end
            end
          end
          PH_R_LOW: begin
            phase_next = PH_R_WAIT;
          end
          PH_R_WAIT: begin
            shift_byte_next = {line_sample, shift_byte[7:1]};
            crc_reg_next    = crc_shift;
            phase_next      = PH_R_TAIL;
          end
          PH_R_TAIL: begin
            bit_index_next = bit_inc;
            if (bit_inc == 3'd0) begin
              last_read_next = shift_byte;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end else begin
              phase_next         = PH_R_LOW;
              drive_release_next = 1'b0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      crc_reg       <= '0;
      presence_flag <= 1'b0;
      drive_release <= 1'b1;
      last_read     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      crc_reg       <= crc_reg_next;
      presence_flag <= presence_flag_next;
      drive_release <= drive_release_next;
      last_read     <= last_read_next;
    end
  end

  always_comb begin
    result.line_release = drive_release_next;
    result.busy_res     = (phase_next != PH_IDLE);
    result.done_res     = done;
    result.presence     = presence_flag_next;
    result.read_data    = last_read_next;
    result.crc_value    = crc_reg_next;
    result.rejected     = rej;
  end

endmodule

// File: hw/rtl/owbm_out_stage.sv
// ----------------------------------------------------------------------------
// owbm_out_stage
// Result register with a one-entry skid buffer on the output channel.
// ----------------------------------------------------------------------------
module owbm_out_stage
  import owbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    head_valid, skid_valid;
  result_t head, skid;

  // The skid entry only fills while the head is held, so the input side
  // stalls exactly when the skid entry is occupied.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load) begin
        if (!head_valid || !out_stall) begin
          head_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (!out_stall) begin
        head_valid <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (!head_valid || !out_stall) begin
        head <= load_data;
      end else begin
        skid <= load_data;
      end
    end else if (!out_stall && skid_valid) begin
      head <= skid;
    end
  end

  assign out_valid = head_valid;
  assign out_data  = head;

endmodule

// File: hw/rtl/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Tick-driven 1-Wire bus master with Dallas CRC-8 over the bits read.
// ----------------------------------------------------------------------------
// Every beat on the input channel is either a tick carrying the sampled bus
// level or a command (reset with presence detect, write byte, read byte), and
// produces exactly one result beat that shows the bus drive and status after
// that item. The block takes one item per clock while in_stall is low: the
// timing state machine advances in the cycle of acceptance and the result
// goes out from the result register. A one-entry skid buffer behind that
// register lets the input keep flowing for one extra beat while the output
// stalls; in_stall rises only when that buffer is occupied. Timing
// registers may be written only while no beat is in flight.
module one_wire_bus_master_unit
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           opcode,
  input  logic                 line_sample,
  input  logic [7:0]           write_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 line_release,
  output logic                 busy_res,
  output logic                 done_res,
  output logic                 presence,
  output logic [7:0]           read_data,
  output logic [7:0]           crc_value,
  output logic                 rejected
);

  cfg_bank_t cfg_bank;
  result_t   step_result;
  result_t   out_data;
  logic      stage_full;
  logic      accept;

  assign in_stall = stage_full;
  assign accept   = in_valid && !stage_full;

  owbm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_bank  (cfg_bank)
  );

  owbm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .cfg_bank    (cfg_bank),
    .opcode      (opcode),
    .line_sample (line_sample),
    .write_data  (write_data),
    .result      (step_result)
  );

  owbm_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (step_result),
    .full      (stage_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign line_release = out_data.line_release;
  assign busy_res     = out_data.busy_res;
  assign done_res     = out_data.done_res;
  assign presence     = out_data.presence;
  assign read_data    = out_data.read_data;
  assign crc_value    = out_data.crc_value;
  assign rejected     = out_data.rejected;

endmodule

// File: hw/rtl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the bus master, attached to the top level by bind.
// ----------------------------------------------------------------------------
module owbm_checker
  import owbm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       line_release,
  input logic       busy_res,
  input logic       done_res,
  input logic       rejected,
  input logic [7:0] read_data,
  input logic [7:0] crc_value
);

  // A command can only be turned away while an operation runs, and ignoring
  // it leaves that operation running.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("rejected beat shows the block idle");

  // Completion always returns the machine to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !rejected)
    else $error("done beat shows busy or rejected");

  // An idle master never holds the bus low.
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> line_release)
    else $error("idle master pulls the bus low");

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(crc_value) && $stable(read_data))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .line_release (line_release),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .rejected     (rejected),
  .read_data    (read_data),
  .crc_value    (crc_value)
);

// File: tb/one_wire_bus_master_unit_test.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit_test
// Self-checking bench for the tick-driven 1-Wire bus master. A directed table
// first checks idle ticks at the power-up timings, then walks a full reset
// slot at short timings with commands refused while it runs, then bytes
// written and read at the shortest timings. Random command and tick traffic
// then runs under several timing settings. Typed rows are checked against
// fixed values, every other result beat against an in-bench model of the
// slot sequencer and its CRC-8. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_SETTINGS    = 6;
  localparam int RANDOM_ITEMS    = 100;

  localparam logic [7:0] DALLAS_POLY = 8'h8C;

  typedef enum {ROW_ITEM, ROW_TIMING} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    opcode_t              op;
    logic                 level;
    logic [7:0]           wd;
    int unsigned          rep;
    bit                   typed;
    result_t              want;
    logic [CFG_WIDTH-1:0] value;
  } row_t;

  localparam result_t ANY = '0;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           opcode;
  logic                 line_sample;
  logic [7:0]           write_data;
  logic                 out_valid;
  logic                 out_stall;
  logic                 line_release;
  logic                 busy_res;
  logic                 done_res;
  logic                 presence;
  logic [7:0]           read_data;
  logic [7:0]           crc_value;
  logic                 rejected;

  // Bench copy of the slot sequencer.
  logic [CFG_WIDTH-1:0] timing [CFG_NUM];
  phase_t               ow_phase;
  count_t               ow_ticks;
  logic [2:0]           ow_bit;
  logic [7:0]           ow_shift;
  logic [7:0]           ow_crc;
  logic [7:0]           ow_last;
  logic                 ow_presence;
  logic                 ow_release;

  result_t     bus_status_q [$];
  row_t        plan [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps      = 1'b0;
  bit          hold_off_req = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  one_wire_bus_master_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .line_sample  (line_sample),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_release (line_release),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .presence     (presence),
    .read_data    (read_data),
    .crc_value    (crc_value),
    .rejected     (rejected)
  );

  function automatic logic [CFG_WIDTH-1:0] slot_len(phase_t ph);
    case (ph)
      PH_RST_LOW:  return timing[REG_RESET_LOW];
      PH_RST_WAIT: return timing[REG_PRESENCE_WAIT];
      PH_RST_TAIL: return timing[REG_RESET_TAIL];
      PH_W_LOW:    return timing[REG_LOW_PULSE];
      PH_W_DATA:   return timing[REG_SLOT];
      PH_W_REC:    return timing[REG_RECOVERY];
      PH_R_LOW:    return timing[REG_LOW_PULSE];
      PH_R_WAIT:   return timing[REG_SAMPLE_DELAY];
      PH_R_TAIL:   return timing[REG_READ_TAIL];
      default:     return '0;
    endcase
  endfunction

  function automatic void enter_phase(phase_t ph, logic rel);
    ow_phase   = ph;
    ow_ticks   = '0;
    ow_release = rel;
  endfunction

  // Steps to the next bit of the byte; returns 1 once all eight are done.
  function automatic bit advance_bit(bit reading);
    ow_bit = ow_bit + 3'd1;
    if (!reading) ow_shift = ow_shift >> 1;
    if (ow_bit == 3'd0) begin
      if (reading) ow_last = ow_shift;
      enter_phase(PH_IDLE, 1'b1);
      return 1'b1;
    end
    if (reading) enter_phase(PH_R_LOW, 1'b0);
    else enter_phase(PH_W_LOW, 1'b0);
    return 1'b0;
  endfunction

  function automatic bit finish_phase(logic level);
    logic fb;
    case (ow_phase)
      PH_RST_LOW: enter_phase(PH_RST_WAIT, 1'b1);
      PH_RST_WAIT: begin
        ow_presence = !level;
        enter_phase(PH_RST_TAIL, 1'b1);
      end
      PH_RST_TAIL: begin
        enter_phase(PH_IDLE, 1'b1);
        return 1'b1;
      end
      PH_W_LOW: enter_phase(PH_W_DATA, ow_shift[0]);
      PH_W_DATA: begin
        // A one bit has no recovery part: the slot already ran released.
        if (ow_shift[0]) return advance_bit(1'b0);
        enter_phase(PH_W_REC, 1'b1);
      end
      PH_W_REC: return advance_bit(1'b0);
      PH_R_LOW: enter_phase(PH_R_WAIT, 1'b1);
      PH_R_WAIT: begin
        ow_shift = {level, ow_shift[7:1]};
        fb = ow_crc[0] ^ level;
        ow_crc = ow_crc >> 1;
        if (fb) ow_crc = ow_crc ^ DALLAS_POLY;
        enter_phase(PH_R_TAIL, 1'b1);
      end
      PH_R_TAIL: return advance_bit(1'b1);
      default: enter_phase(PH_IDLE, 1'b1);
    endcase
    return 1'b0;
  endfunction

  function automatic result_t bus_master_step(opcode_t op, logic level, logic [7:0] wd);
    result_t r;
    logic    done;
    logic    rej;
    done = 1'b0;
    rej  = 1'b0;
    if (op != OP_TICK) begin
      if (ow_phase != PH_IDLE) begin
        rej = 1'b1;
      end else if (op == OP_RESET) begin
        ow_crc = '0;
        enter_phase(PH_RST_LOW, 1'b0);
      end else if (op == OP_WRITE) begin
        ow_shift = wd;
        ow_bit   = '0;
        enter_phase(PH_W_LOW, 1'b0);
      end else begin
        ow_shift = '0;
        ow_bit   = '0;
        enter_phase(PH_R_LOW, 1'b0);
      end
    end else if (ow_phase != PH_IDLE) begin
      if (ow_ticks != COUNT_MAX) ow_ticks = ow_ticks + 1'b1;
      if (ow_ticks >= slot_len(ow_phase) || ow_ticks == COUNT_MAX) begin
        done = finish_phase(level);
      end
    end
    r.line_release = ow_release;
    r.busy_res     = (ow_phase != PH_IDLE);
    r.done_res     = done;
    r.presence     = ow_presence;
    r.read_data    = ow_last;
    r.crc_value    = ow_crc;
    r.rejected     = rej;
    return r;
  endfunction

  function automatic result_t flags(logic rel, logic busy, logic done, logic pres, logic rej);
    result_t r;
    r = '0;
    r.line_release = rel;
    r.busy_res     = busy;
    r.done_res     = done;
    r.presence     = pres;
    r.rejected     = rej;
    return r;
  endfunction

  function automatic void add_row(row_kind_t kind, opcode_t op, logic level, logic [7:0] wd,
                                  int unsigned rep, bit typed, result_t want,
                                  logic [CFG_WIDTH-1:0] value);
    row_t row;
    row.kind  = kind;
    row.op    = op;
    row.level = level;
    row.wd    = wd;
    row.rep   = rep;
    row.typed = typed;
    row.want  = want;
    row.value = value;
    plan.push_back(row);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one beat and holds it until taken; the expected status is queued
  // at the edge that takes it.
  task automatic send_item(opcode_t op, logic level, logic [7:0] wd, bit typed, result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    line_sample <= level;
    write_data  <= wd;
    do @(posedge clk); while (in_stall);
    predicted = bus_master_step(op, level, wd);
    bus_status_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus_status_q.size() != 0);
  endtask

  // Runs any open operation to its end, then lets the pipeline empty out.
  task automatic settle();
    while (ow_phase != PH_IDLE) begin
      send_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, ANY);
    end
    wait_results();
    repeat (3) @(posedge clk);
  endtask

  task automatic load_timing(input logic [CFG_WIDTH-1:0] vals [CFG_NUM]);
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      timing[i] = vals[i];
    end
    cfg_write <= 1'b0;
  endtask

  // Mostly complete operations: a command when idle, then ticks with random
  // bus levels, salted with idle ticks and commands that arrive while busy.
  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned r;
    opcode_t     op;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 79) == 0) wait_results();
      r = $urandom_range(0, 99);
      if (ow_phase == PH_IDLE && r < 10) begin
        // An idle tick changes nothing and does not count.
        send_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, ANY);
      end else begin
        if (ow_phase == PH_IDLE || r < 8) begin
          case ($urandom_range(0, 9))
            0, 1:          op = OP_RESET;
            2, 3, 4, 5:    op = OP_WRITE;
            default:       op = OP_READ;
          endcase
        end else begin
          op = OP_TICK;
        end
        send_item(op, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, ANY);
        sent++;
      end
    end
  endtask

  initial begin : rx_stall_gen
    int unsigned r;
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall <= 1'b0;
          run = $urandom_range(40, 150);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 6);
        end else if (r < 88) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else if (r < 97) begin
          out_stall <= 1'b1;
          run = $urandom_range(4, 15);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(25, 60);
        end
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (bus_status_q.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        want = bus_status_q.pop_front();
        check_field("line_release", want.line_release, line_release);
        check_field("busy_res", want.busy_res, busy_res);
        check_field("done_res", want.done_res, done_res);
        check_field("presence", want.presence, presence);
        check_field("read_data", want.read_data, read_data);
        check_field("crc_value", want.crc_value, crc_value);
        check_field("rejected", want.rejected, rejected);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("one_wire_bus_master_unit_test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_WIDTH-1:0] vals [CFG_NUM];
    int unsigned          pick;

    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_LOW_PULSE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_TICK;
    line_sample = 1'b1;
    write_data  = '0;

    timing[REG_LOW_PULSE]     = 16'd3;
    timing[REG_SLOT]          = 16'd60;
    timing[REG_RECOVERY]      = 16'd10;
    timing[REG_RESET_LOW]     = 16'd500;
    timing[REG_PRESENCE_WAIT] = 16'd90;
    timing[REG_RESET_TAIL]    = 16'd410;
    timing[REG_SAMPLE_DELAY]  = 16'd10;
    timing[REG_READ_TAIL]     = 16'd55;
    ow_phase    = PH_IDLE;
    ow_ticks    = '0;
    ow_bit      = '0;
    ow_shift    = '0;
    ow_crc      = '0;
    ow_last     = '0;
    ow_presence = 1'b0;
    ow_release  = 1'b1;

    // Power-up: idle ticks change nothing.
    add_row(ROW_ITEM, OP_TICK, 1'b0, 8'h00, 1, 1'b1,
            flags(1'b1, 1'b0, 1'b0, 1'b0, 1'b0), '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'hFF, 1, 1'b1,
            flags(1'b1, 1'b0, 1'b0, 1'b0, 1'b0), '0);
    // Four ticks per phase: a full reset slot with a device answering, and
    // every command refused while the reset runs.
    add_row(ROW_TIMING, OP_TICK, 1'b0, 8'h00, 1, 1'b0, ANY, 16'd4);
    add_row(ROW_ITEM, OP_RESET, 1'b1, 8'h00, 1, 1'b1,
            flags(1'b0, 1'b1, 1'b0, 1'b0, 1'b0), '0);
    add_row(ROW_ITEM, OP_RESET, 1'b1, 8'h00, 1, 1'b1,
            flags(1'b0, 1'b1, 1'b0, 1'b0, 1'b1), '0);
    add_row(ROW_ITEM, OP_WRITE, 1'b0, 8'hFF, 1, 1'b1,
            flags(1'b0, 1'b1, 1'b0, 1'b0, 1'b1), '0);
    add_row(ROW_ITEM, OP_READ, 1'b0, 8'h00, 1, 1'b1,
            flags(1'b0, 1'b1, 1'b0, 1'b0, 1'b1), '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 3, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 1, 1'b1,
            flags(1'b1, 1'b1, 1'b0, 1'b0, 1'b0), '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 3, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b0, 8'h00, 1, 1'b1,
            flags(1'b1, 1'b1, 1'b0, 1'b1, 1'b0), '0);
    add_row(ROW_ITEM, OP_TICK, 1'b0, 8'h00, 3, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 1, 1'b1,
            flags(1'b1, 1'b0, 1'b1, 1'b1, 1'b0), '0);
    // Shortest timings: bytes of all zeros and all ones out and in, then a
    // reset with nobody answering, which also clears the CRC.
    add_row(ROW_TIMING, OP_TICK, 1'b0, 8'h00, 1, 1'b0, ANY, 16'd1);
    add_row(ROW_ITEM, OP_WRITE, 1'b1, 8'h00, 1, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 24, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_WRITE, 1'b0, 8'hFF, 1, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b0, 8'h00, 16, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_READ, 1'b1, 8'h00, 1, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 24, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_READ, 1'b0, 8'h00, 1, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b0, 8'h00, 24, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_RESET, 1'b0, 8'h00, 1, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 2, 1'b0, ANY, '0);
    add_row(ROW_ITEM, OP_TICK, 1'b1, 8'h00, 1, 1'b1,
            flags(1'b1, 1'b0, 1'b1, 1'b0, 1'b0), '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_TIMING) begin
        settle();
        for (int i = 0; i < CFG_NUM; i++) vals[i] = plan[r].value;
        load_timing(vals);
      end else begin
        repeat (plan[r].rep) begin
          send_item(plan[r].op, plan[r].level, plan[r].wd, plan[r].typed, plan[r].want);
        end
      end
    end
    settle();

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) vals[i] = 16'($urandom_range(13, 40));
        else if (pick < 6) vals[i] = 16'($urandom_range(5, 12));
        else vals[i] = 16'($urandom_range(1, 4));
      end
      load_timing(vals);
      // The output side holds off for a long stretch while beats keep coming.
      if (k == 2) hold_off_req = 1'b1;
      random_traffic(RANDOM_ITEMS);
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("one_wire_bus_master_unit_test passed");
    end else begin
      $display("one_wire_bus_master_unit_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_cfg_regs.sv
hw/rtl/owbm_core.sv
hw/rtl/owbm_out_stage.sv
hw/rtl/one_wire_bus_master_unit.sv
hw/rtl/owbm_checker.sv
tb/one_wire_bus_master_unit_test.sv
